// ----- src/rgb5a3_pkg.sv -----
// Shared types, constants and texel expansion tables for the RGB5A3 tile decoder.
package rgb5a3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;
    localparam int TEXEL_W   = 16;
    localparam int IDX_W     = 20;
    localparam int ARGB_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int TCOL_W = ($clog2((MAX_WIDTH + 3) / 4) > 0) ? $clog2((MAX_WIDTH + 3) / 4) : 1;
    localparam int TROW_W = ($clog2((MAX_HEIGHT + 3) / 4) > 0) ? $clog2((MAX_HEIGHT + 3) / 4) : 1;
    localparam int X_W    = TCOL_W + 2;
    localparam int Y_W    = TROW_W + 2;
    localparam int CMP_W  = 16;
    localparam int SUM_W  = Y_W + WD_W + 1;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic               last;
    } t_mid_entry;

    typedef struct packed {
        logic [IDX_W-1:0]  pixel_index;
        logic [ARGB_W-1:0] argb_word;
        logic              frame_last;
    } t_out_entry;

    localparam logic [7:0] SCALE5 [0:31] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    localparam logic [7:0] SCALE3 [0:7] = '{
        8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
    };

    function automatic logic [WD_W-1:0] clamp_w(input logic [DIM_W-1:0] v);
        logic [WD_W-1:0] r;
        if (v == '0) begin
            r = WD_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WD_W'(MAX_WIDTH);
        end else begin
            r = WD_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HD_W-1:0] clamp_h(input logic [DIM_W-1:0] v);
        logic [HD_W-1:0] r;
        if (v == '0) begin
            r = HD_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HD_W'(MAX_HEIGHT);
        end else begin
            r = HD_W'(v);
        end
        return r;
    endfunction

    // A 4-bit channel times 255/15 is exactly the nibble repeated.
    function automatic logic [ARGB_W-1:0] expand_texel(input logic [TEXEL_W-1:0] t);
        logic [ARGB_W-1:0] r;
        if (t[15]) begin
            r = {8'hFF, SCALE5[t[14:10]], SCALE5[t[9:5]], SCALE5[t[4:0]]};
        end else begin
            r = {SCALE3[t[14:12]], t[11:8], t[11:8], t[7:4], t[7:4], t[3:0], t[3:0]};
        end
        return r;
    endfunction

endpackage

// ----- src/rgb5a3_front.sv -----
// Front end: size registers, tile position counters and padding classification.
module rgb5a3_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgb5a3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgb5a3_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                                i_accept,
    input  logic [rgb5a3_pkg::TEXEL_W-1:0]      i_texel,
    output logic                                o_mq_push,
    output rgb5a3_pkg::t_mid_entry              o_mq_entry,
    output logic [rgb5a3_pkg::WD_W-1:0]         o_width
);

    logic [rgb5a3_pkg::WD_W-1:0]   r_w;
    logic [rgb5a3_pkg::HD_W-1:0]   r_h;
    logic [1:0]                    r_col, n_col;
    logic [1:0]                    r_row, n_row;
    logic [rgb5a3_pkg::TCOL_W-1:0] r_tcol, n_tcol;
    logic [rgb5a3_pkg::TROW_W-1:0] r_trow, n_trow;

    logic [rgb5a3_pkg::X_W-1:0]    x;
    logic [rgb5a3_pkg::Y_W-1:0]    y;
    logic [rgb5a3_pkg::CMP_W-1:0]  x_c, y_c, w_c, h_c;
    logic [rgb5a3_pkg::CMP_W-1:0]  tiles_w, tiles_h, tcol_inc, trow_inc;
    logic                          visible;

    assign o_cfg_ready = 1'b1;
    assign o_width     = r_w;

    assign x   = {r_tcol, r_col};
    assign y   = {r_trow, r_row};
    assign x_c = rgb5a3_pkg::CMP_W'(x);
    assign y_c = rgb5a3_pkg::CMP_W'(y);
    assign w_c = rgb5a3_pkg::CMP_W'(r_w);
    assign h_c = rgb5a3_pkg::CMP_W'(r_h);

    assign tiles_w  = (w_c + rgb5a3_pkg::CMP_W'(3)) >> 2;
    assign tiles_h  = (h_c + rgb5a3_pkg::CMP_W'(3)) >> 2;
    assign tcol_inc = rgb5a3_pkg::CMP_W'(r_tcol) + rgb5a3_pkg::CMP_W'(1);
    assign trow_inc = rgb5a3_pkg::CMP_W'(r_trow) + rgb5a3_pkg::CMP_W'(1);

    assign visible = (x_c < w_c) && (y_c < h_c);

    assign o_mq_push        = i_accept && visible;
    assign o_mq_entry.texel = i_texel;
    assign o_mq_entry.x     = x;
    assign o_mq_entry.y     = y;
    assign o_mq_entry.last  = (x_c == w_c - rgb5a3_pkg::CMP_W'(1)) &&
                              (y_c == h_c - rgb5a3_pkg::CMP_W'(1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_tcol = r_tcol;
        n_trow = r_trow;
        if (i_accept) begin
            n_col = r_col + 2'd1;
            if (r_col == 2'd3) begin
                n_row = r_row + 2'd1;
                if (r_row == 2'd3) begin
                    if (tcol_inc >= tiles_w) begin
                        n_tcol = '0;
                        if (trow_inc >= tiles_h) begin
                            n_trow = '0;
                        end else begin
                            n_trow = rgb5a3_pkg::TROW_W'(trow_inc);
                        end
                    end else begin
                        n_tcol = rgb5a3_pkg::TCOL_W'(tcol_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= rgb5a3_pkg::WD_W'(1);
            r_h    <= rgb5a3_pkg::HD_W'(1);
            r_col  <= '0;
            r_row  <= '0;
            r_tcol <= '0;
            r_trow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
            if (i_cfg_valid && i_cfg_index == rgb5a3_pkg::CFG_WIDTH) begin
                r_w <= rgb5a3_pkg::clamp_w(i_cfg_data);
            end
            if (i_cfg_valid && i_cfg_index == rgb5a3_pkg::CFG_HEIGHT) begin
                r_h <= rgb5a3_pkg::clamp_h(i_cfg_data);
            end
        end
    end

endmodule

// ----- src/rgb5a3_mid_queue.sv -----
// Short queue of classified texels between the front end and the back end.
module rgb5a3_mid_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rgb5a3_pkg::t_mid_entry i_entry,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output rgb5a3_pkg::t_mid_entry o_entry
);

    rgb5a3_pkg::t_mid_entry          r_mem [rgb5a3_pkg::MQ_DEPTH];
    logic [rgb5a3_pkg::MQ_PTR_W-1:0] r_wr, r_rd;
    logic [rgb5a3_pkg::MQ_CNT_W-1:0] r_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == rgb5a3_pkg::MQ_CNT_W'(rgb5a3_pkg::MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + rgb5a3_pkg::MQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + rgb5a3_pkg::MQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + rgb5a3_pkg::MQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - rgb5a3_pkg::MQ_CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/rgb5a3_back.sv -----
// Back end: pixel index and color expansion stage followed by the result queue.
module rgb5a3_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_mq_empty,
    input  rgb5a3_pkg::t_mid_entry        i_mq_entry,
    output logic                          o_mq_pop,
    input  logic [rgb5a3_pkg::WD_W-1:0]   i_width,
    input  logic                          i_pop,
    output logic                          o_empty,
    output rgb5a3_pkg::t_out_entry        o_entry
);

    rgb5a3_pkg::t_out_entry          r_s1, n_s1;
    logic                            r_s1_valid;
    rgb5a3_pkg::t_out_entry          r_mem [rgb5a3_pkg::OQ_DEPTH];
    logic [rgb5a3_pkg::OQ_PTR_W-1:0] r_wr, r_rd;
    logic [rgb5a3_pkg::OQ_CNT_W-1:0] r_cnt;
    logic [rgb5a3_pkg::OQ_CNT_W:0]   occupancy;
    logic [rgb5a3_pkg::SUM_W-1:0]    index_sum;
    logic                            do_pop;

    assign occupancy = (rgb5a3_pkg::OQ_CNT_W + 1)'(r_cnt) +
                       (rgb5a3_pkg::OQ_CNT_W + 1)'(r_s1_valid);
    assign o_mq_pop  = !i_mq_empty &&
                       (occupancy < (rgb5a3_pkg::OQ_CNT_W + 1)'(rgb5a3_pkg::OQ_DEPTH));

    assign index_sum = rgb5a3_pkg::SUM_W'(i_mq_entry.y) * rgb5a3_pkg::SUM_W'(i_width) +
                       rgb5a3_pkg::SUM_W'(i_mq_entry.x);

    always_comb begin
        n_s1.pixel_index = rgb5a3_pkg::IDX_W'(index_sum);
        n_s1.argb_word   = rgb5a3_pkg::expand_texel(i_mq_entry.texel);
        n_s1.frame_last  = i_mq_entry.last;
    end

    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (o_mq_pop) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid) begin
            r_mem[r_wr] <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= o_mq_pop;
            if (r_s1_valid) begin
                r_wr <= r_wr + rgb5a3_pkg::OQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + rgb5a3_pkg::OQ_PTR_W'(1);
            end
            if (r_s1_valid && !do_pop) begin
                r_cnt <= r_cnt + rgb5a3_pkg::OQ_CNT_W'(1);
            end else if (do_pop && !r_s1_valid) begin
                r_cnt <= r_cnt - rgb5a3_pkg::OQ_CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rgb5a3_pkg::OQ_CNT_W'(rgb5a3_pkg::OQ_DEPTH))
        else $error("result queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cnt < rgb5a3_pkg::OQ_CNT_W'(rgb5a3_pkg::OQ_DEPTH) || do_pop))
        else $error("result stage writes into a full queue");

    a_opaque_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mq_pop && i_mq_entry.texel[15]) |=> (r_s1.argb_word[31:24] == 8'hFF))
        else $error("opaque texel expanded without full alpha");
`endif

endmodule

// ----- src/rgb5a3_tiled_texture_decoder.sv -----
// RGB5A3 tiled texture decoder: one texel accepted per cycle while not full, one ARGB pixel per visible texel.
// A visible texel goes through the four-entry queue, the expansion stage register and the result queue.
// Throughput: one texel per cycle while full is low, set by the single index multiplier and expansion stage.
// A four-entry queue parts the position counters from the expansion stage and the result queue.
// Reset (synchronous, active low) sets width and height to 1, the counters to the top-left
// texel and empties both queues.
module rgb5a3_tiled_texture_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rgb5a3_pkg::TEXEL_W-1:0]    i_texel,
    output logic                              empty,
    input  logic                              pop,
    output logic [rgb5a3_pkg::IDX_W-1:0]      o_pixel_index,
    output logic [rgb5a3_pkg::ARGB_W-1:0]     o_argb_word,
    output logic                              o_frame_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgb5a3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgb5a3_pkg::DIM_W-1:0]      i_cfg_data
);

    logic                        accept;
    logic                        mq_push, mq_pop, mq_empty;
    rgb5a3_pkg::t_mid_entry      mq_in, mq_out;
    rgb5a3_pkg::t_out_entry      result;
    logic [rgb5a3_pkg::WD_W-1:0] width;

    assign accept = push && !full;

    rgb5a3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_texel     (i_texel),
        .o_mq_push   (mq_push),
        .o_mq_entry  (mq_in),
        .o_width     (width)
    );

    rgb5a3_mid_queue u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_entry (mq_in),
        .o_full  (full),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_entry (mq_out)
    );

    rgb5a3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_empty (mq_empty),
        .i_mq_entry (mq_out),
        .o_mq_pop   (mq_pop),
        .i_width    (width),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_entry    (result)
    );

    assign o_pixel_index = result.pixel_index;
    assign o_argb_word   = result.argb_word;
    assign o_frame_last  = result.frame_last;

endmodule
